### hdl/mi3_pkg.sv
// shared widths, types and the cofactor index table for the 3x3 inverse
`timescale 1ns / 1ps
package mi3_pkg;

  // element formats
  localparam int IN_W     = 16;
  localparam int IN_FRAC  = 8;
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 16;
  localparam int NL       = 9;

  // internal widths
  localparam int PR_W  = 2 * IN_W;
  localparam int CF_W  = PR_W + 1;
  localparam int DP_W  = IN_W + CF_W;
  localparam int DET_W = DP_W + 2;
  localparam int SH    = IN_FRAC + OUT_FRAC + 1;
  localparam int NUM_W = ((CF_W + SH > DET_W) ? CF_W + SH : DET_W) + 1;
  localparam int DEN_W = DET_W + 1;
  localparam int Q_W   = OUT_W + 1;

  // saturation limits on the quotient magnitude
  localparam logic [Q_W-1:0] LIM_POS = {2'b00, {(OUT_W-1){1'b1}}};
  localparam logic [Q_W-1:0] LIM_NEG = {2'b01, {(OUT_W-1){1'b0}}};

  typedef logic [NL-1:0][IN_W-1:0] mat_t;

  typedef struct packed {
    logic [2:0][IN_W-1:0]    row1;
    logic [NL-1:0][CF_W-1:0] cof;
  } cof_t;

  typedef struct packed {
    logic                     sing;
    logic [NL-1:0]            neg;
    logic [NL-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]         den;
  } div_in_t;

  typedef struct packed {
    logic                   sing;
    logic [NL-1:0]          neg;
    logic [NL-1:0]          ovf;
    logic [NL-1:0][Q_W-1:0] quo;
  } div_out_t;

  // element indices {a, b, c, d} of cofactor k = a*b - c*d, by rows of the inverse
  function automatic logic [15:0] cof_tab(input int k);
    logic [15:0] t;
    unique case (k)
      0: t = 16'h4857;
      1: t = 16'h2718;
      2: t = 16'h1524;
      3: t = 16'h5638;
      4: t = 16'h0826;
      5: t = 16'h2305;
      6: t = 16'h3746;
      7: t = 16'h1607;
      8: t = 16'h0413;
      default: t = 16'h0000;
    endcase
    return t;
  endfunction

endpackage

### hdl/mi3_cof.sv
// two stages: element products, then the nine adjugate cofactors
`timescale 1ns / 1ps
module mi3_cof import mi3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  mat_t mat_i,
  output logic valid_o,
  input  logic stall_i,
  output cof_t cof_o
);

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic signed [IN_W-1:0] el [NL];
  logic signed [PR_W-1:0] pab_d [NL];
  logic signed [PR_W-1:0] pcd_d [NL];
  logic signed [PR_W-1:0] pab_q [NL];
  logic signed [PR_W-1:0] pcd_q [NL];
  logic [2:0][IN_W-1:0]   row1_q;
  cof_t                   cof_q;

  // ready chain
  assign rdy[2]  = !stall_i;
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign stall_o = !rdy[0];
  assign valid_o = v_q[1];
  assign cof_o   = cof_q;

  // products a*b and c*d for each cofactor
  for (genvar k = 0; k < NL; k++) begin : g_prod
    localparam logic [15:0] T = cof_tab(k);
    assign el[k]    = $signed(mat_i[k]);
    assign pab_d[k] = el[T[15:12]] * el[T[11:8]];
    assign pcd_d[k] = el[T[7:4]] * el[T[3:0]];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      for (int k = 0; k < NL; k++) begin
        pab_q[k] <= pab_d[k];
        pcd_q[k] <= pcd_d[k];
      end
      row1_q <= {mat_i[2], mat_i[1], mat_i[0]};
    end
    if (rdy[1] && v_q[0]) begin
      for (int k = 0; k < NL; k++) begin
        cof_q.cof[k] <= CF_W'(pab_q[k]) - CF_W'(pcd_q[k]);
      end
      cof_q.row1 <= row1_q;
    end
  end

endmodule

### hdl/mi3_det.sv
// two stages: determinant products, then the sum and the divider operands
`timescale 1ns / 1ps
module mi3_det import mi3_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    stall_o,
  input  cof_t    cof_i,
  output logic    valid_o,
  input  logic    stall_i,
  output div_in_t div_o
);

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic signed [DP_W-1:0]  dp_q [3];
  logic [NL-1:0][CF_W-1:0] cof_q;
  logic signed [DET_W-1:0] det;
  logic [DET_W-1:0]        magd;
  div_in_t                 div_d;
  div_in_t                 div_q;

  assign rdy[2]  = !stall_i;
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign stall_o = !rdy[0];
  assign valid_o = v_q[1];
  assign div_o   = div_q;

  // determinant, magnitudes and the rounding numerators
  always_comb begin
    logic [CF_W-1:0] magc;
    det  = DET_W'(dp_q[0]) + DET_W'(dp_q[1]) + DET_W'(dp_q[2]);
    magd = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    div_d.sing = (det == '0);
    div_d.den  = {magd, 1'b0};
    for (int k = 0; k < NL; k++) begin
      magc = cof_q[k][CF_W-1] ? CF_W'(-cof_q[k]) : cof_q[k];
      div_d.neg[k] = cof_q[k][CF_W-1] ^ det[DET_W-1];
      div_d.num[k] = (NUM_W'(magc) << SH) + NUM_W'(magd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  // expansion along the first row
  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= $signed(cof_i.row1[i]) * $signed(cof_i.cof[3*i]);
      end
      cof_q <= cof_i.cof;
    end
    if (rdy[1] && v_q[0]) begin
      div_q <= div_d;
    end
  end

endmodule

### hdl/mi3_div.sv
// nine-lane restoring divider, one quotient bit per pipeline stage
`timescale 1ns / 1ps
module mi3_div import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  div_in_t  div_i,
  output logic     valid_o,
  input  logic     stall_i,
  output div_out_t div_o
);

  logic [Q_W-1:0] v_q;
  logic [Q_W:0]   rdy;

  // index 0 is the module input, index s+1 the register of stage s
  logic [NL-1:0][NUM_W-1:0] st_r   [Q_W+1];
  logic [NL-1:0][Q_W-1:0]   st_q   [Q_W+1];
  logic [NL-1:0]            st_ovf [Q_W+1];
  logic [NL-1:0]            st_neg [Q_W+1];
  logic [DEN_W-1:0]         st_den [Q_W+1];
  logic                     st_sng [Q_W+1];

  logic [NL-1:0][NUM_W-1:0] r_q   [Q_W];
  logic [NL-1:0][Q_W-1:0]   q_q   [Q_W];
  logic [NL-1:0]            ovf_q [Q_W];
  logic [NL-1:0]            neg_q [Q_W];
  logic [DEN_W-1:0]         den_q [Q_W];
  logic                     sng_q [Q_W];

  assign rdy[Q_W] = !stall_i;
  assign stall_o  = !rdy[0];
  assign valid_o  = v_q[Q_W-1];

  assign st_r[0]   = div_i.num;
  assign st_q[0]   = '0;
  assign st_neg[0] = div_i.neg;
  assign st_den[0] = div_i.den;
  assign st_sng[0] = div_i.sing;

  // quotient of at least 2^Q_W saturates
  for (genvar l = 0; l < NL; l++) begin : g_pre
    assign st_ovf[0][l] = (div_i.num[l] >> Q_W) >= NUM_W'(div_i.den);
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [NL-1:0][NUM_W-1:0] r_d;
    logic [NL-1:0][Q_W-1:0]   q_d;

    assign rdy[s] = !v_q[s] || rdy[s+1];

    // trial subtract of the divisor at bit B
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic ge;
      assign ge     = (st_r[s][l] >> B) >= NUM_W'(st_den[s]);
      assign r_d[l] = ge ? st_r[s][l] - (NUM_W'(st_den[s]) << B) : st_r[s][l];
      assign q_d[l] = st_q[s][l] | (Q_W'(ge) << B);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= (s == 0) ? valid_i : v_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && ((s == 0) ? valid_i : v_q[(s == 0) ? 0 : s-1])) begin
        r_q[s]   <= r_d;
        q_q[s]   <= q_d;
        ovf_q[s] <= st_ovf[s];
        neg_q[s] <= st_neg[s];
        den_q[s] <= st_den[s];
        sng_q[s] <= st_sng[s];
      end
    end

    assign st_r[s+1]   = r_q[s];
    assign st_q[s+1]   = q_q[s];
    assign st_ovf[s+1] = ovf_q[s];
    assign st_neg[s+1] = neg_q[s];
    assign st_den[s+1] = den_q[s];
    assign st_sng[s+1] = sng_q[s];
  end

  assign div_o.sing = st_sng[Q_W];
  assign div_o.neg  = st_neg[Q_W];
  assign div_o.ovf  = st_ovf[Q_W];
  assign div_o.quo  = st_q[Q_W];

endmodule

### hdl/matrix_inverse_3x3.sv
// top level of the 3x3 matrix inverse: cofactors, determinant, divider, output stage
//
// One request on the input channel carries a 3x3 matrix of signed Q8.8 elements
// (m11_i .. m33_i, by rows); it is taken at a rising edge with in_valid_i high and
// in_stall_o low. One result follows on the output channel: the inverse as signed
// Q16.16 elements r11_o .. r33_o, rounded to nearest with ties away from zero and
// saturated, plus singular_o, which is high with all elements zero when the
// determinant is zero. A result is taken with out_valid_o high and out_stall_i low.
// The path has two stages of products and cofactors, two of determinant,
// 33 divider stages (one quotient bit each, nine lanes side by side) and an
// output register. A new matrix may enter every cycle while in_stall_o is low.
// Every stage carries its own valid bit; a stage holds only while it is full and
// the one after it cannot take its data, so a stalled receiver fills the empty
// stages first and the block keeps taking requests until 38 are in flight.
// Reset clears every valid bit; the block keeps no other state.
`timescale 1ns / 1ps
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [IN_W-1:0] m11_i,
  input  logic signed [IN_W-1:0] m12_i,
  input  logic signed [IN_W-1:0] m13_i,
  input  logic signed [IN_W-1:0] m21_i,
  input  logic signed [IN_W-1:0] m22_i,
  input  logic signed [IN_W-1:0] m23_i,
  input  logic signed [IN_W-1:0] m31_i,
  input  logic signed [IN_W-1:0] m32_i,
  input  logic signed [IN_W-1:0] m33_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OUT_W-1:0] r11_o,
  output logic signed [OUT_W-1:0] r12_o,
  output logic signed [OUT_W-1:0] r13_o,
  output logic signed [OUT_W-1:0] r21_o,
  output logic signed [OUT_W-1:0] r22_o,
  output logic signed [OUT_W-1:0] r23_o,
  output logic signed [OUT_W-1:0] r31_o,
  output logic signed [OUT_W-1:0] r32_o,
  output logic signed [OUT_W-1:0] r33_o,
  output logic                   singular_o
);

  mat_t     mat;
  cof_t     cof;
  div_in_t  div_in;
  div_out_t div_out;
  logic     cof_valid, cof_stall;
  logic     det_valid, det_stall;
  logic     div_valid, div_stall;

  logic                    out_v_q;
  logic                    out_rdy;
  logic [NL-1:0][OUT_W-1:0] res_d;
  logic [NL-1:0][OUT_W-1:0] res_q;
  logic                    sing_q;

  assign mat[0] = m11_i;
  assign mat[1] = m12_i;
  assign mat[2] = m13_i;
  assign mat[3] = m21_i;
  assign mat[4] = m22_i;
  assign mat[5] = m23_i;
  assign mat[6] = m31_i;
  assign mat[7] = m32_i;
  assign mat[8] = m33_i;

  mi3_cof u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .mat_i   (mat),
    .valid_o (cof_valid),
    .stall_i (cof_stall),
    .cof_o   (cof)
  );

  mi3_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_valid),
    .stall_o (cof_stall),
    .cof_i   (cof),
    .valid_o (det_valid),
    .stall_i (det_stall),
    .div_o   (div_in)
  );

  mi3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (det_valid),
    .stall_o (det_stall),
    .div_i   (div_in),
    .valid_o (div_valid),
    .stall_i (div_stall),
    .div_o   (div_out)
  );

  assign out_rdy   = !out_v_q || !out_stall_i;
  assign div_stall = !out_rdy;

  // sign, saturation and the singular case
  always_comb begin
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] mag;
    logic [Q_W-1:0] sgn;
    for (int l = 0; l < NL; l++) begin
      lim = div_out.neg[l] ? LIM_NEG : LIM_POS;
      mag = (div_out.ovf[l] || (div_out.quo[l] > lim)) ? lim : div_out.quo[l];
      sgn = div_out.neg[l] ? (~mag + Q_W'(1)) : mag;
      res_d[l] = div_out.sing ? '0 : sgn[OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_valid) begin
      res_q  <= res_d;
      sing_q <= div_out.sing;
    end
  end

  assign out_valid_o = out_v_q;
  assign singular_o  = sing_q;
  assign r11_o = res_q[0];
  assign r12_o = res_q[1];
  assign r13_o = res_q[2];
  assign r21_o = res_q[3];
  assign r22_o = res_q[4];
  assign r23_o = res_q[5];
  assign r31_o = res_q[6];
  assign r32_o = res_q[7];
  assign r33_o = res_q[8];

endmodule

### hdl/mi3_checker.sv
// port-level checks on the 3x3 matrix inverse and the bind that attaches them
`timescale 1ns / 1ps
module mi3_checker import mi3_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic signed [IN_W-1:0]  m11_i,
  input logic signed [IN_W-1:0]  m12_i,
  input logic signed [IN_W-1:0]  m13_i,
  input logic signed [IN_W-1:0]  m21_i,
  input logic signed [IN_W-1:0]  m22_i,
  input logic signed [IN_W-1:0]  m23_i,
  input logic signed [IN_W-1:0]  m31_i,
  input logic signed [IN_W-1:0]  m32_i,
  input logic signed [IN_W-1:0]  m33_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [OUT_W-1:0] r11_o,
  input logic signed [OUT_W-1:0] r12_o,
  input logic signed [OUT_W-1:0] r13_o,
  input logic signed [OUT_W-1:0] r21_o,
  input logic signed [OUT_W-1:0] r22_o,
  input logic signed [OUT_W-1:0] r23_o,
  input logic signed [OUT_W-1:0] r31_o,
  input logic signed [OUT_W-1:0] r32_o,
  input logic signed [OUT_W-1:0] r33_o,
  input logic                    singular_o
);

  // no result shows in the cycle after reset is seen
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // a singular matrix gives an all-zero inverse
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> r11_o == 0 && r12_o == 0 && r13_o == 0 &&
      r21_o == 0 && r22_o == 0 && r23_o == 0 && r31_o == 0 && r32_o == 0 && r33_o == 0)
    else $error("singular result with nonzero elements");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(singular_o) && $stable(r11_o) &&
      $stable(r22_o) && $stable(r33_o) && $stable(r12_o) && $stable(r21_o))
    else $error("stalled result changed");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (.*);

### tb/testbench.sv
// self-checking testbench for the 3x3 matrix inverse: random and directed matrices
`timescale 1ns / 1ps
module testbench;
  import mi3_pkg::*;

  typedef struct packed {
    logic                   sing;
    logic [NL-1:0][OUT_W-1:0] el;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  mat_t mat_drv = '0;
  logic signed [OUT_W-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
  logic singular;

  mat_t     matrix_queue[$];
  inverse_t inverse_queue[$];
  int       accepted = 0;
  bit       failed = 1'b0;

  matrix_inverse_3x3 u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .m11_i(mat_drv[0]), .m12_i(mat_drv[1]), .m13_i(mat_drv[2]),
    .m21_i(mat_drv[3]), .m22_i(mat_drv[4]), .m23_i(mat_drv[5]),
    .m31_i(mat_drv[6]), .m32_i(mat_drv[7]), .m33_i(mat_drv[8]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .r11_o(r11), .r12_o(r12), .r13_o(r13),
    .r21_o(r21), .r22_o(r22), .r23_o(r23),
    .r31_o(r31), .r32_o(r32), .r33_o(r33),
    .singular_o(singular)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one inverse element: cofactor scaled and divided, rounded half away from zero
  function automatic logic [OUT_W-1:0] scaled_element(logic signed [127:0] cof,
                                                     logic signed [127:0] det);
    logic signed [127:0] nm, dm, q, lim;
    logic neg;
    nm  = (cof < 0) ? -cof : cof;
    dm  = (det < 0) ? -det : det;
    neg = (cof < 0) != (det < 0);
    q   = ((nm <<< (IN_FRAC + OUT_FRAC + 1)) + dm) / (dm <<< 1);
    lim = neg ? (128'sd1 <<< (OUT_W - 1)) : ((128'sd1 <<< (OUT_W - 1)) - 1);
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[OUT_W-1:0];
  endfunction

  // full inverse by adjugate over determinant
  function automatic inverse_t invert(mat_t m);
    logic signed [127:0] e[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det;
    inverse_t r;
    for (int i = 0; i < 9; i++) e[i] = $signed(m[i]);
    adj[0] = e[4] * e[8] - e[5] * e[7];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[2] * e[3] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[4] * e[6];
    adj[7] = e[1] * e[6] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) r.el[i] = scaled_element(adj[i], det);
    end
    return r;
  endfunction

  function automatic bit quiet_stretch();
    return accepted >= 700 && accepted < 1000;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        inverse_queue.push_back(invert(mat_drv));
        void'(matrix_queue.pop_front());
        accepted <= accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (((in_valid && !in_stall) ? matrix_queue.size() > 0 : matrix_queue.size() > 0)
            && (quiet_stretch() || $urandom_range(99) >= 19)) begin
          in_valid <= 1'b1;
          mat_drv  <= matrix_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall
  always @(posedge clk) begin
    if (rst_n) out_stall <= !quiet_stretch() && ($urandom_range(99) < 19);
  end

  // result monitor
  always @(posedge clk) begin
    logic [NL-1:0][OUT_W-1:0] got;
    inverse_t exp_inv;
    if (rst_n && out_valid && !out_stall) begin
      got = {r33, r32, r31, r23, r22, r21, r13, r12, r11};
      if (inverse_queue.size() == 0) begin
        $error("result with no matrix outstanding");
        failed = 1'b1;
      end else begin
        exp_inv = inverse_queue.pop_front();
        if (singular !== exp_inv.sing) begin
          $error("singular expected %0d got %0d", exp_inv.sing, singular);
          failed = 1'b1;
        end
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== exp_inv.el[i]) begin
            $error("r%0d%0d expected %0d got %0d", i / 3 + 1, i % 3 + 1,
                   $signed(exp_inv.el[i]), $signed(got[i]));
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic mat_t rand_matrix();
    mat_t m;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0, 1:    m[i] = IN_W'($urandom_range(1023) - 512);
        2:       m[i] = IN_W'($urandom_range(7) - 4);
        default: m[i] = IN_W'($urandom);
      endcase
    end
    // occasional singular forms: repeated row or zero column
    if ($urandom_range(9) == 0) begin
      m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
    end else if ($urandom_range(19) == 0) begin
      m[1] = '0; m[4] = '0; m[7] = '0;
    end
    return m;
  endfunction

  // stimulus and end of run
  initial begin
    // identity, zero, extremes, negative determinant, near-singular overflow
    matrix_queue.push_back({16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0,
                            16'sd0, 16'sd0, 16'sd256});
    matrix_queue.push_back('0);
    matrix_queue.push_back({9{16'h8000}});
    matrix_queue.push_back({9{16'h7fff}});
    matrix_queue.push_back({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0,
                            16'h0, 16'h0, 16'h8000});
    matrix_queue.push_back({16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0,
                            16'h0, 16'h0, 16'h8000});
    matrix_queue.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                            16'sd0, 16'sd0, 16'sd1});
    matrix_queue.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd32765, 16'sd32766,
                            16'sd0, 16'sd32766, 16'sd32767});
    matrix_queue.push_back({16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0, 16'sd256});
    matrix_queue.push_back({16'sd768, 16'sd0, 16'sd0, 16'sd0, 16'sd768, 16'sd0,
                            16'sd0, 16'sd0, 16'sd768});
    matrix_queue.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                            16'h7fff, 16'h8000, 16'h0001});
    matrix_queue.push_back({16'sd2, 16'sd1, 16'sd1, 16'sd1, 16'sd2, 16'sd1,
                            16'sd1, 16'sd1, 16'sd2});
    for (int n = 0; n < 1700; n++) matrix_queue.push_back(rand_matrix());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (matrix_queue.size() != 0 || inverse_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed) begin
      $display("matrix_inverse_3x3: match");
    end else begin
      $display("matrix_inverse_3x3: mismatch");
    end
    $finish;
  end

  // timeout
  initial begin
    #3ms;
    $display("matrix_inverse_3x3: mismatch");
    $finish;
  end

endmodule
